// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every edge outside reset
`define HPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies consequence in the next
`define HPQ_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

// ===== sv/hpq_pkg.sv =====
// ----------------------------------------------------------------------------
// hpq_pkg
// Shared constants and types of the binary max-heap priority queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hpq_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned KEY_W        = 32;
  localparam int unsigned STAT_W       = 2;
  localparam int unsigned CNT_W        = 5;
  localparam int unsigned IN_DATA_W    = 32;
  localparam int unsigned OUT_DATA_W   = 40;
  localparam int unsigned OUT_PAD_W    = OUT_DATA_W - KEY_W - CNT_W;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [KEY_W-1:0] removed;
    logic [CNT_W-1:0]        count;
  } hpq_res_t;

  typedef struct packed {
    logic a_gt_v;
    logic a_lt_v;
    logic b_gt_v;
    logic b_gt_a;
  } hpq_cmp_t;

endpackage

// ===== sv/hpq_mem.sv =====
// ----------------------------------------------------------------------------
// hpq_mem
// Heap entry store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpq_mem import hpq_pkg::*; #(
  parameter int unsigned DEPTH = CAPACITY_DEF,
  parameter int unsigned AW    = $clog2(CAPACITY_DEF)
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [AW-1:0]           waddr_i,
  input  logic signed [KEY_W-1:0] wdata_i,
  input  logic [AW-1:0]           raddr_a_i,
  input  logic [AW-1:0]           raddr_b_i,
  output logic signed [KEY_W-1:0] rdata_a_o,
  output logic signed [KEY_W-1:0] rdata_b_o
);

  logic signed [KEY_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== sv/hpq_cmp.sv =====
// ----------------------------------------------------------------------------
// hpq_cmp
// Shared signed compare unit for sift-up and sift-down steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpq_cmp import hpq_pkg::*; (
  input  logic signed [KEY_W-1:0] a_i,
  input  logic signed [KEY_W-1:0] b_i,
  input  logic signed [KEY_W-1:0] v_i,
  output hpq_cmp_t                cmp_o
);

  assign cmp_o.a_gt_v = a_i > v_i;
  assign cmp_o.a_lt_v = a_i < v_i;
  assign cmp_o.b_gt_v = b_i > v_i;
  assign cmp_o.b_gt_a = b_i > a_i;

endmodule

// ===== sv/hpq_core.sv =====
// ----------------------------------------------------------------------------
// hpq_core
// Sequencer: insert sift-up and remove sift-down, one heap level per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module hpq_core import hpq_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  parameter int unsigned AW       = $clog2(CAPACITY_DEF),
  parameter int unsigned CW       = $clog2(CAPACITY_DEF + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    in_op_i,
  input  logic signed [KEY_W-1:0] in_key_i,
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  output hpq_res_t                res_o,
  output logic                    mem_we_o,
  output logic [AW-1:0]           mem_waddr_o,
  output logic signed [KEY_W-1:0] mem_wdata_o,
  output logic [AW-1:0]           mem_raddr_a_o,
  output logic [AW-1:0]           mem_raddr_b_o,
  input  logic signed [KEY_W-1:0] mem_rdata_a_i,
  input  logic signed [KEY_W-1:0] mem_rdata_b_i,
  output logic signed [KEY_W-1:0] cmp_v_o,
  input  hpq_cmp_t                cmp_i
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RM    = 6'b000010,
    S_UP    = 6'b000100,
    S_DN    = 6'b001000,
    S_PLACE = 6'b010000,
    S_RESP  = 6'b100000
  } state_e;

  state_e                  state_q, state_d;
  logic [CW-1:0]           fill_q, fill_d;
  logic [AW-1:0]           pos_q, pos_d;
  logic signed [KEY_W-1:0] v_q, v_d;
  logic signed [KEY_W-1:0] rem_q, rem_d;
  logic [STAT_W-1:0]       stat_q, stat_d;

  logic [CW-1:0]           fm1;
  logic [AW-1:0]           p_up, p_up2;
  logic [CW:0]             lidx, ridx, cidx, c2a, c2b;
  logic                    l_ok, r_ok, take_l, take_r;
  logic [CW+CNT_W-1:0]     cnt_ext;

  function automatic logic [AW-1:0] clamp(input logic [CW:0] idx);
    if (idx < (CW+1)'(CAPACITY)) begin
      clamp = idx[AW-1:0];
    end else begin
      clamp = '0;
    end
  endfunction

  assign fm1   = fill_q - CW'(1);
  assign p_up  = (pos_q - AW'(1)) >> 1;
  assign p_up2 = (p_up - AW'(1)) >> 1;
  assign lidx  = (CW+1)'({pos_q, 1'b1});
  assign ridx  = lidx + (CW+1)'(1);
  assign l_ok  = lidx < {1'b0, fill_q};
  assign r_ok  = ridx < {1'b0, fill_q};
  // left child wins ties; right only if strictly larger than the current best
  assign take_r = r_ok && (cmp_i.a_gt_v ? cmp_i.b_gt_a : cmp_i.b_gt_v);
  assign take_l = l_ok && cmp_i.a_gt_v && !take_r;
  assign cidx   = take_r ? ridx : lidx;
  assign c2a    = (CW+1)'({cidx[AW-1:0], 1'b1});
  assign c2b    = c2a + (CW+1)'(1);

  assign cmp_v_o     = v_q;
  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESP);
  assign cnt_ext     = {{CNT_W{1'b0}}, fill_q};
  assign res_o.status  = stat_q;
  assign res_o.removed = rem_q;
  assign res_o.count   = cnt_ext[CNT_W-1:0];

  always_comb begin
    state_d       = state_q;
    fill_d        = fill_q;
    pos_d         = pos_q;
    v_d           = v_q;
    rem_d         = rem_q;
    stat_d        = stat_q;
    mem_we_o      = 1'b0;
    mem_waddr_o   = pos_q;
    mem_wdata_o   = v_q;
    mem_raddr_a_o = '0;
    mem_raddr_b_o = '0;
    case (state_q)
      S_IDLE: begin
        mem_raddr_a_o = (in_op_i == OP_INSERT) ? clamp({2'b00, fm1[CW-1:1]}) : '0;
        mem_raddr_b_o = clamp({1'b0, fm1});
        if (in_valid_i) begin
          v_d    = in_key_i;
          pos_d  = fill_q[AW-1:0];
          rem_d  = '0;
          stat_d = STAT_OK;
          if (in_op_i == OP_INSERT) begin
            if (fill_q == CW'(CAPACITY)) begin
              stat_d  = STAT_FULL;
              state_d = S_RESP;
            end else begin
              fill_d  = fill_q + CW'(1);
              state_d = (fill_q == '0) ? S_PLACE : S_UP;
            end
          end else begin
            if (fill_q == '0) begin
              stat_d  = STAT_EMPTY;
              rem_d   = '1;
              state_d = S_RESP;
            end else begin
              fill_d  = fm1;
              state_d = S_RM;
            end
          end
        end
      end
      S_RM: begin
        rem_d         = mem_rdata_a_i;
        v_d           = mem_rdata_b_i;
        pos_d         = '0;
        mem_raddr_a_o = clamp((CW+1)'(1));
        mem_raddr_b_o = clamp((CW+1)'(2));
        state_d       = (fill_q == '0) ? S_RESP : S_DN;
      end
      S_DN: begin
        mem_we_o = 1'b1;
        if (take_l || take_r) begin
          mem_wdata_o   = take_r ? mem_rdata_b_i : mem_rdata_a_i;
          pos_d         = cidx[AW-1:0];
          mem_raddr_a_o = clamp(c2a);
          mem_raddr_b_o = clamp(c2b);
        end else begin
          state_d = S_RESP;
        end
      end
      S_UP: begin
        mem_we_o = 1'b1;
        if (cmp_i.a_lt_v) begin
          mem_wdata_o   = mem_rdata_a_i;
          pos_d         = p_up;
          mem_raddr_a_o = p_up2;
          state_d       = (p_up == '0) ? S_PLACE : S_UP;
        end else begin
          state_d = S_RESP;
        end
      end
      S_PLACE: begin
        mem_we_o = 1'b1;
        state_d  = S_RESP;
      end
      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    v_q    <= v_d;
    rem_q  <= rem_d;
    stat_q <= stat_d;
  end

  `HPQ_ASSERT(a_fill_max, fill_q <= CW'(CAPACITY), "entry count above capacity")
  `HPQ_ASSERT_NEXT(a_fill_inc, in_valid_i && in_ready_o && in_op_i == OP_INSERT && fill_q != CW'(CAPACITY), fill_q == $past(fill_q) + CW'(1), "insert did not bump count")
  `HPQ_ASSERT(a_pos_range, (state_q == S_UP || state_q == S_DN || state_q == S_PLACE) |-> CW'(pos_q) < fill_q, "sift position outside heap")
  `HPQ_ASSERT(a_waddr_range, mem_we_o |-> CW'(mem_waddr_o) < CW'(CAPACITY), "write beyond store")

endmodule

// ===== sv/binary_max_heap_priority_queue.sv =====
// A full insert or an empty remove goes straight to the result; an insert sifts up and a
// remove sifts down, except when it takes the only entry.
// Throughput: one operation at a time; the next transfer is taken once the result sits
// in the output register. The sequencer walks one heap level per cycle through the
// compare unit.
// Reset: asynchronous, clears entry count and handshake state; store is not swept.
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue
// Binary max-heap of signed 32-bit priorities with insert and remove-max.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module binary_max_heap_priority_queue import hpq_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [31:0] key_value
  input  logic                  s_axis_tuser,  // [0] opcode
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [31:0] removed_value, [36:32] entry_count
  output logic [STAT_W-1:0]     m_axis_tuser   // [1:0] status
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic                    mem_we;
  logic [AW-1:0]           mem_waddr, mem_raddr_a, mem_raddr_b;
  logic signed [KEY_W-1:0] mem_wdata, mem_rdata_a, mem_rdata_b, cmp_v;
  hpq_cmp_t                cmp;
  hpq_res_t                res, out_q;
  logic                    res_valid, res_ready, out_valid_q;

  hpq_core #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_op_i       (s_axis_tuser),
    .in_key_i      (s_axis_tdata[KEY_W-1:0]),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_a_o (mem_raddr_a),
    .mem_raddr_b_o (mem_raddr_b),
    .mem_rdata_a_i (mem_rdata_a),
    .mem_rdata_b_i (mem_rdata_b),
    .cmp_v_o       (cmp_v),
    .cmp_i         (cmp)
  );

  hpq_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

  hpq_cmp u_cmp (
    .a_i   (mem_rdata_a),
    .b_i   (mem_rdata_b),
    .v_i   (cmp_v),
    .cmp_o (cmp)
  );

  // output register: result waits here while the next operation runs
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_q.count, out_q.removed};
  assign m_axis_tuser  = out_q.status;

endmodule

// ===== tb/tb_binary_max_heap_priority_queue.sv =====
// ----------------------------------------------------------------------------
// tb_binary_max_heap_priority_queue
// Self-checking bench for the max-heap priority queue. A directed table covers
// the empty and full cases, the key extremes and equal priorities. Random
// traffic follows, in bursts biased towards insert or remove so the heap keeps
// filling and draining. Random gaps on the input and stalls on the output run
// in phases. Every result transfer is checked against the row's given result or a behavioural heap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_binary_max_heap_priority_queue;
  import hpq_pkg::*;

  localparam int unsigned RAND_OPS   = 700;
  localparam int unsigned NUM_PHASES = 4;
  localparam int unsigned DIR_ROWS   = 24;

  typedef struct {
    logic              op;
    logic [KEY_W-1:0]  key;
    bit                fixed;   // expected result given in the row
    logic [STAT_W-1:0] status;
    logic [KEY_W-1:0]  removed;
    logic [CNT_W-1:0]  count;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = OP_INSERT;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STAT_W-1:0]     m_axis_tuser;

  // behavioural heap
  logic signed [KEY_W-1:0] heap_mem [CAPACITY_DEF];
  int unsigned             heap_fill = 0;

  hpq_res_t pending_res [$];
  int       err_count = 0;
  int       gap_pct   = 0;
  int       stall_pct = 0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{OP_REMOVE, 32'h0000_0000, 1'b1, STAT_EMPTY, 32'hFFFF_FFFF, 5'd0},
    '{OP_INSERT, 32'h7FFF_FFFF, 1'b1, STAT_OK,    32'h0000_0000, 5'd1},
    '{OP_INSERT, 32'h8000_0000, 1'b1, STAT_OK,    32'h0000_0000, 5'd2},
    '{OP_INSERT, 32'h0000_0005, 1'b0, STAT_OK,    '0, '0},
    '{OP_INSERT, 32'h0000_0005, 1'b0, STAT_OK,    '0, '0},
    '{OP_INSERT, 32'hFFFF_FFFF, 1'b0, STAT_OK,    '0, '0},
    '{OP_INSERT, 32'h0000_0000, 1'b0, STAT_OK,    '0, '0},
    '{OP_INSERT, 32'h7FFF_FFFE, 1'b0, STAT_OK,    '0, '0},
    '{OP_INSERT, 32'h8000_0001, 1'b0, STAT_OK,    '0, '0},
    '{OP_INSERT, 32'h0000_0005, 1'b0, STAT_OK,    '0, '0},
    '{OP_INSERT, 32'h0000_1234, 1'b0, STAT_OK,    '0, '0},
    '{OP_INSERT, 32'hFFFF_FFFE, 1'b0, STAT_OK,    '0, '0},
    '{OP_INSERT, 32'h5555_5555, 1'b0, STAT_OK,    '0, '0},
    '{OP_INSERT, 32'hAAAA_AAAA, 1'b0, STAT_OK,    '0, '0},
    '{OP_INSERT, 32'h0000_0003, 1'b0, STAT_OK,    '0, '0},
    '{OP_INSERT, 32'h0000_0005, 1'b0, STAT_OK,    '0, '0},
    '{OP_INSERT, 32'h7FFF_FFFF, 1'b0, STAT_OK,    '0, '0},
    '{OP_INSERT, 32'h0000_0001, 1'b1, STAT_FULL,  32'h0000_0000, 5'd16},
    '{OP_REMOVE, 32'hFFFF_FFFF, 1'b1, STAT_OK,    32'h7FFF_FFFF, 5'd15},
    '{OP_REMOVE, 32'h0000_0000, 1'b0, STAT_OK,    '0, '0},
    '{OP_REMOVE, 32'h0000_0000, 1'b0, STAT_OK,    '0, '0},
    '{OP_REMOVE, 32'h0000_0000, 1'b0, STAT_OK,    '0, '0},
    '{OP_REMOVE, 32'h0000_0000, 1'b0, STAT_OK,    '0, '0},
    '{OP_REMOVE, 32'h0000_0000, 1'b0, STAT_OK,    '0, '0}
  };

  binary_max_heap_priority_queue u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [31:0] key_value
    .s_axis_tuser  (s_axis_tuser),   // [0] opcode
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [31:0] removed_value, [36:32] entry_count
    .m_axis_tuser  (m_axis_tuser)    // [1:0] status
  );

  always #1 clk_i = ~clk_i;

  // Applies one operation to the behavioural heap and returns its result.
  function automatic hpq_res_t heap_apply(input logic op, input logic signed [KEY_W-1:0] key);
    hpq_res_t                res;
    int unsigned             pos;
    int unsigned             lc;
    int unsigned             rc;
    int unsigned             big;
    logic signed [KEY_W-1:0] tmp;
    res.status  = STAT_OK;
    res.removed = '0;
    if (op == OP_INSERT) begin
      if (heap_fill >= CAPACITY_DEF) begin
        res.status = STAT_FULL;
      end else begin
        pos = heap_fill;
        heap_fill++;
        while (pos > 0 && heap_mem[(pos - 1) / 2] < key) begin
          heap_mem[pos] = heap_mem[(pos - 1) / 2];
          pos = (pos - 1) / 2;
        end
        heap_mem[pos] = key;
      end
    end else if (heap_fill == 0) begin
      res.status  = STAT_EMPTY;
      res.removed = -32'sd1;
    end else begin
      res.removed = heap_mem[0];
      heap_fill--;
      heap_mem[0] = heap_mem[heap_fill];
      pos = 0;
      forever begin
        lc  = 2 * pos + 1;
        rc  = lc + 1;
        big = pos;
        if (lc < heap_fill && heap_mem[lc] > heap_mem[big]) big = lc;
        if (rc < heap_fill && heap_mem[rc] > heap_mem[big]) big = rc;
        if (big == pos) break;
        tmp           = heap_mem[pos];
        heap_mem[pos] = heap_mem[big];
        heap_mem[big] = tmp;
        pos           = big;
      end
    end
    res.count = heap_fill[CNT_W-1:0];
    return res;
  endfunction

  // One input transfer; the valid stays high into the next call unless a gap is taken.
  task automatic send_op(input logic op, input logic [KEY_W-1:0] key, input bit fixed,
                         input hpq_res_t fixed_res);
    hpq_res_t res;
    while ($urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= key;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    res = heap_apply(op, key);
    pending_res.push_back(fixed ? fixed_res : res);
  endtask

  task automatic drain_wait();
    s_axis_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
  endtask

  // result side: check, then choose the next tready
  always @(posedge clk_i) begin
    hpq_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_res.size() == 0) begin
        $error("unexpected result transfer: status %0d removed_value %0d entry_count %0d",
               m_axis_tuser, $signed(m_axis_tdata[31:0]), m_axis_tdata[36:32]);
        err_count++;
      end else begin
        want = pending_res.pop_front();
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          err_count++;
        end
        if (m_axis_tdata[31:0] !== want.removed) begin
          $error("removed_value: expected %0d, got %0d", want.removed,
                 $signed(m_axis_tdata[31:0]));
          err_count++;
        end
        if (m_axis_tdata[36:32] !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, m_axis_tdata[36:32]);
          err_count++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  initial begin
    #400_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    hpq_res_t         fixed_res;
    logic             op;
    logic [KEY_W-1:0] key;
    int               insert_pct;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      fixed_res.status  = dir_rows[r].status;
      fixed_res.removed = dir_rows[r].removed;
      fixed_res.count   = dir_rows[r].count;
      send_op(dir_rows[r].op, dir_rows[r].key, dir_rows[r].fixed, fixed_res);
    end
    drain_wait();

    insert_pct = 50;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 82; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 82; end
        default: begin gap_pct = 20; stall_pct = 20; end
      endcase
      for (int n = 0; n < RAND_OPS / NUM_PHASES; n++) begin
        // bursts that fill, drain or churn the heap
        if (n % 24 == 0) begin
          case ($urandom_range(0, 2))
            0: insert_pct = 85;
            1: insert_pct = 15;
            default: insert_pct = 50;
          endcase
        end
        op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
        case ($urandom_range(0, 3))
          0: key = $urandom_range(0, 7) - 4;  // duplicates likely
          1: begin
            case ($urandom_range(0, 3))
              0: key = 32'h7FFF_FFFF;
              1: key = 32'h8000_0000;
              2: key = 32'h0000_0000;
              default: key = 32'hFFFF_FFFF;
            endcase
          end
          default: key = $urandom;
        endcase
        fixed_res = '0;
        send_op(op, key, 1'b0, fixed_res);
      end
      drain_wait();
    end

    repeat (16) @(posedge clk_i);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
